@@ rtl/image_rotate_blit_core_assert.svh @@
`ifndef IMAGE_ROTATE_BLIT_CORE_ASSERT_SVH
`define IMAGE_ROTATE_BLIT_CORE_ASSERT_SVH

// checked at every rising clock edge, quiet while reset is high
`define IRB_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every rising clock edge, reset included
`define IRB_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ rtl/irb_pkg.sv @@
package irb_pkg;

   localparam int MAX_SRC_WIDTH_DEF  = 256;
   localparam int MAX_SRC_HEIGHT_DEF = 256;
   localparam int FRAME_WIDTH_DEF    = 480;
   localparam int FRAME_HEIGHT_DEF   = 320;

   localparam int TRIG_W       = 18;
   localparam int DIM_W        = 9;
   localparam int COORD_W      = 8;
   localparam int PIXEL_W      = 16;
   localparam int FRAME_ADDR_W = 18;
   localparam int FRAC_W       = 16;

   localparam int OFFSET_W = COORD_W + 1;
   localparam int PROD_W   = TRIG_W + OFFSET_W;
   localparam int SUM_W    = PROD_W + 1;
   localparam int POS_W    = SUM_W - FRAC_W + 1;
   localparam int FSUM_W   = DIM_W + 1;

   // wide enough for the largest store the parameters allow
   localparam int STORE_ADDR_W = 20;

   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = 3;
   localparam int FIFO_CNT_W = 4;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   localparam logic [REG_IDX_W-1:0] REG_COS        = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_SIN        = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_DEST_X     = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_DEST_Y     = 3'd5;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_RENDER = 1'b1;

   localparam logic signed [TRIG_W-1:0] COS_RESET = 18'sd65536;
   localparam logic signed [TRIG_W-1:0] SIN_RESET = 18'sd0;
   localparam logic [DIM_W-1:0] SRC_WIDTH_RESET   = 9'd256;
   localparam logic [DIM_W-1:0] SRC_HEIGHT_RESET  = 9'd256;
   localparam logic [DIM_W-1:0] DEST_X_RESET      = 9'd0;
   localparam logic [DIM_W-1:0] DEST_Y_RESET      = 9'd0;

   localparam logic [PIXEL_W-1:0] BLACK = 16'h0000;

   typedef struct packed {
      logic               op;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic [PIXEL_W-1:0] pixel;
   } req_type;

   typedef struct packed {
      logic [PIXEL_W-1:0]      color;
      logic                    outside;
      logic                    rejected;
      logic [FRAME_ADDR_W-1:0] frame_address;
   } rsp_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0] cos_q16;
      logic signed [TRIG_W-1:0] sin_q16;
      logic [DIM_W-1:0]         src_width;
      logic [DIM_W-1:0]         src_height;
      logic [DIM_W-1:0]         dest_x;
      logic [DIM_W-1:0]         dest_y;
   } cfg_type;

   typedef struct packed {
      logic                    valid;
      logic                    render;
      logic                    load_en;
      logic                    rejected;
      logic                    in_image;
      logic [STORE_ADDR_W-1:0] store_addr;
      logic [PIXEL_W-1:0]      pixel;
      logic [FRAME_ADDR_W-1:0] frame_addr;
   } stage_type;

   typedef struct packed {
      logic [FIFO_CNT_W-1:0] count;
   } fifo_status_type;

endpackage

@@ rtl/irb_xform.sv @@
module irb_xform #(
   parameter int MAX_SRC_WIDTH  = irb_pkg::MAX_SRC_WIDTH_DEF,
   parameter int MAX_SRC_HEIGHT = irb_pkg::MAX_SRC_HEIGHT_DEF,
   parameter int FRAME_WIDTH    = irb_pkg::FRAME_WIDTH_DEF,
   parameter int FRAME_HEIGHT   = irb_pkg::FRAME_HEIGHT_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  irb_pkg::req_type    in_data,
   input  irb_pkg::cfg_type    cfg,
   output irb_pkg::stage_type  out_stage
);

   localparam int OW  = irb_pkg::OFFSET_W;
   localparam int PW  = irb_pkg::PROD_W;
   localparam int SW  = irb_pkg::SUM_W;
   localparam int QW  = irb_pkg::POS_W;
   localparam int FW  = irb_pkg::FSUM_W;
   localparam int SAW = irb_pkg::STORE_ADDR_W;
   localparam int FAW = irb_pkg::FRAME_ADDR_W;
   localparam int PXW = irb_pkg::PIXEL_W;
   localparam int CW  = irb_pkg::COORD_W;
   localparam int DW  = irb_pkg::DIM_W;
   localparam int FRW = irb_pkg::FRAC_W;

   logic [CW-1:0] cx;
   logic [CW-1:0] cy;

   // stage 1: offsets, rejection, frame position, store address of loads
   typedef struct packed {
      logic                 valid;
      logic                 render;
      logic                 load_en;
      logic                 rejected;
      logic signed [OW-1:0] fx;
      logic signed [OW-1:0] fy;
      logic [FW-1:0]        frame_x;
      logic [FW-1:0]        frame_y;
      logic [SAW-1:0]       addr;
      logic [PXW-1:0]       pixel;
   } s1_type;

   // stage 2: products and frame address
   typedef struct packed {
      logic                 valid;
      logic                 render;
      logic                 load_en;
      logic                 rejected;
      logic signed [PW-1:0] cos_fx;
      logic signed [PW-1:0] sin_fy;
      logic signed [PW-1:0] cos_fy;
      logic signed [PW-1:0] sin_fx;
      logic [FAW-1:0]       frame_addr;
      logic [SAW-1:0]       addr;
      logic [PXW-1:0]       pixel;
   } s2_type;

   // stage 3: rotated source position
   typedef struct packed {
      logic                 valid;
      logic                 render;
      logic                 load_en;
      logic                 rejected;
      logic signed [QW-1:0] sx;
      logic signed [QW-1:0] sy;
      logic [FAW-1:0]       frame_addr;
      logic [SAW-1:0]       addr;
      logic [PXW-1:0]       pixel;
   } s3_type;

   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   irb_pkg::stage_type s4_ff, s4_in;

   logic signed [SW-1:0] sum_x;
   logic signed [SW-1:0] sum_y;

   assign cx = cfg.src_width[DW-1:1];
   assign cy = cfg.src_height[DW-1:1];

   always_comb begin
      s1_in.valid    = in_valid;
      s1_in.render   = (in_data.op == irb_pkg::OP_RENDER);
      s1_in.load_en  = (in_data.op == irb_pkg::OP_LOAD) &&
                       (32'(in_data.col) < 32'(MAX_SRC_WIDTH)) &&
                       (32'(in_data.row) < 32'(MAX_SRC_HEIGHT));
      s1_in.rejected = (cfg.src_width == '0) || (cfg.src_height == '0) ||
                       (32'(cfg.src_width) > 32'(MAX_SRC_WIDTH)) ||
                       (32'(cfg.src_height) > 32'(MAX_SRC_HEIGHT)) ||
                       (32'(cfg.dest_x) + 32'(cfg.src_width) > 32'(FRAME_WIDTH)) ||
                       (32'(cfg.dest_y) + 32'(cfg.src_height) > 32'(FRAME_HEIGHT)) ||
                       (DW'(in_data.col) >= cfg.src_width) ||
                       (DW'(in_data.row) >= cfg.src_height);
      s1_in.fx       = $signed({1'b0, in_data.col}) - $signed({1'b0, cx});
      s1_in.fy       = $signed({1'b0, in_data.row}) - $signed({1'b0, cy});
      s1_in.frame_x  = FW'(cfg.dest_x) + FW'(in_data.col);
      s1_in.frame_y  = FW'(cfg.dest_y) + FW'(in_data.row);
      s1_in.addr     = SAW'(32'(in_data.row) * 32'(MAX_SRC_WIDTH) + 32'(in_data.col));
      s1_in.pixel    = in_data.pixel;
   end

   always_comb begin
      s2_in.valid      = s1_ff.valid;
      s2_in.render     = s1_ff.render;
      s2_in.load_en    = s1_ff.load_en;
      s2_in.rejected   = s1_ff.rejected;
      s2_in.cos_fx     = PW'(cfg.cos_q16) * PW'(s1_ff.fx);
      s2_in.sin_fy     = PW'(cfg.sin_q16) * PW'(s1_ff.fy);
      s2_in.cos_fy     = PW'(cfg.cos_q16) * PW'(s1_ff.fy);
      s2_in.sin_fx     = PW'(cfg.sin_q16) * PW'(s1_ff.fx);
      s2_in.frame_addr = FAW'(32'(s1_ff.frame_y) * 32'(FRAME_WIDTH) + 32'(s1_ff.frame_x));
      s2_in.addr       = s1_ff.addr;
      s2_in.pixel      = s1_ff.pixel;
   end

   always_comb begin
      sum_x            = SW'(s2_ff.cos_fx) + SW'(s2_ff.sin_fy);
      sum_y            = SW'(s2_ff.cos_fy) - SW'(s2_ff.sin_fx);
      s3_in.valid      = s2_ff.valid;
      s3_in.render     = s2_ff.render;
      s3_in.load_en    = s2_ff.load_en;
      s3_in.rejected   = s2_ff.rejected;
      // floor shift by the fraction, then back to image coordinates
      s3_in.sx         = QW'($signed(sum_x[SW-1:FRW])) + QW'($signed({1'b0, cx}));
      s3_in.sy         = QW'($signed(sum_y[SW-1:FRW])) + QW'($signed({1'b0, cy}));
      s3_in.frame_addr = s2_ff.frame_addr;
      s3_in.addr       = s2_ff.addr;
      s3_in.pixel      = s2_ff.pixel;
   end

   always_comb begin
      s4_in.valid      = s3_ff.valid;
      s4_in.render     = s3_ff.render;
      s4_in.load_en    = s3_ff.load_en;
      s4_in.rejected   = s3_ff.rejected;
      s4_in.in_image   = !s3_ff.sx[QW-1] && (s3_ff.sx < $signed(QW'(cfg.src_width))) &&
                         !s3_ff.sy[QW-1] && (s3_ff.sy < $signed(QW'(cfg.src_height)));
      s4_in.store_addr = s3_ff.load_en ? s3_ff.addr :
                         SAW'(32'(s3_ff.sy[QW-2:0]) * 32'(MAX_SRC_WIDTH) +
                              32'(s3_ff.sx[QW-2:0]));
      s4_in.pixel      = s3_ff.pixel;
      s4_in.frame_addr = s3_ff.frame_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
         s2_ff <= '0;
         s3_ff <= '0;
         s4_ff <= '0;
      end else begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
      end
   end

   assign out_stage = s4_ff;

endmodule

@@ rtl/irb_rsp_fifo.sv @@
module irb_rsp_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   input  irb_pkg::rsp_type         push_data,
   input  logic                     pop_ready,
   output logic                     pop_valid,
   output irb_pkg::rsp_type         pop_data,
   output irb_pkg::fifo_status_type status
);

   localparam int PTR_W = irb_pkg::FIFO_PTR_W;
   localparam int CNT_W = irb_pkg::FIFO_CNT_W;

   irb_pkg::rsp_type entries_ff [irb_pkg::FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   assign pop_valid = (count_ff != '0);
   assign pop       = pop_valid && pop_ready;
   assign pop_data  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push_valid) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign status.count = count_ff;

endmodule

@@ rtl/image_rotate_blit_core.sv @@
// render results pass the four transform stages, the store read stage and the result queue before they are offered
// one transaction per cycle while req_ready is high, loads and renders mixed, set by the 5-stage pipeline
// and the single-port image store read or written once per cycle
// an 8-entry result queue keeps taking requests while results wait, until 8 renders are pending
// synchronous reset clears the pipeline and the queue and loads the csr registers with their reset values;
// the image store is not cleared and must be written before it is read
`include "image_rotate_blit_core_assert.svh"

module image_rotate_blit_core #(
   parameter int MAX_SRC_WIDTH  = irb_pkg::MAX_SRC_WIDTH_DEF,
   parameter int MAX_SRC_HEIGHT = irb_pkg::MAX_SRC_HEIGHT_DEF,
   parameter int FRAME_WIDTH    = irb_pkg::FRAME_WIDTH_DEF,
   parameter int FRAME_HEIGHT   = irb_pkg::FRAME_HEIGHT_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  irb_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output irb_pkg::rsp_type               rsp_data,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [irb_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [irb_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [irb_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);

   localparam int STORE_DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
   localparam int AW          = $clog2(STORE_DEPTH);
   localparam int CNT_W       = irb_pkg::FIFO_CNT_W;
   localparam int DW          = irb_pkg::DIM_W;
   localparam int TW          = irb_pkg::TRIG_W;
   localparam int DAW         = irb_pkg::CSR_DATA_W;

   irb_pkg::cfg_type          cfg_ff, cfg_in;
   logic                      csr_write;
   logic [irb_pkg::REG_IDX_W-1:0] csr_index;

   irb_pkg::stage_type        xf_stage;
   logic [AW-1:0]             store_addr;
   logic [irb_pkg::PIXEL_W-1:0] store_mem [STORE_DEPTH];
   logic [irb_pkg::PIXEL_W-1:0] rd_data_ff;

   logic                      s5_valid_ff, s5_valid_in;
   logic                      s5_rejected_ff;
   logic                      s5_in_image_ff;
   logic [irb_pkg::FRAME_ADDR_W-1:0] s5_frame_ff;

   irb_pkg::rsp_type          rsp_push_data;
   irb_pkg::fifo_status_type  fifo_status;
   logic                      req_accept;
   logic                      render_accept;
   logic                      rsp_pop;
   logic [CNT_W-1:0]          pend_ff, pend_in;

   // csr port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[irb_pkg::CSR_ADDR_W-1:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            irb_pkg::REG_COS:        cfg_in.cos_q16    = $signed(pwdata[TW-1:0]);
            irb_pkg::REG_SIN:        cfg_in.sin_q16    = $signed(pwdata[TW-1:0]);
            irb_pkg::REG_SRC_WIDTH:  cfg_in.src_width  = pwdata[DW-1:0];
            irb_pkg::REG_SRC_HEIGHT: cfg_in.src_height = pwdata[DW-1:0];
            irb_pkg::REG_DEST_X:     cfg_in.dest_x     = pwdata[DW-1:0];
            irb_pkg::REG_DEST_Y:     cfg_in.dest_y     = pwdata[DW-1:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         irb_pkg::REG_COS:        prdata = DAW'(unsigned'(cfg_ff.cos_q16));
         irb_pkg::REG_SIN:        prdata = DAW'(unsigned'(cfg_ff.sin_q16));
         irb_pkg::REG_SRC_WIDTH:  prdata = DAW'(cfg_ff.src_width);
         irb_pkg::REG_SRC_HEIGHT: prdata = DAW'(cfg_ff.src_height);
         irb_pkg::REG_DEST_X:     prdata = DAW'(cfg_ff.dest_x);
         irb_pkg::REG_DEST_Y:     prdata = DAW'(cfg_ff.dest_y);
         default:                 prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cos_q16    <= irb_pkg::COS_RESET;
         cfg_ff.sin_q16    <= irb_pkg::SIN_RESET;
         cfg_ff.src_width  <= irb_pkg::SRC_WIDTH_RESET;
         cfg_ff.src_height <= irb_pkg::SRC_HEIGHT_RESET;
         cfg_ff.dest_x     <= irb_pkg::DEST_X_RESET;
         cfg_ff.dest_y     <= irb_pkg::DEST_Y_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // credit: every accepted render owns a queue slot until its result leaves
   assign req_ready     = (pend_ff < CNT_W'(irb_pkg::FIFO_DEPTH));
   assign req_accept    = req_valid && req_ready;
   assign render_accept = req_accept && (req_data.op == irb_pkg::OP_RENDER);
   assign rsp_pop       = rsp_valid && rsp_ready;
   assign pend_in       = pend_ff + CNT_W'(render_accept) - CNT_W'(rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   irb_xform #(
      .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
      .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
      .FRAME_WIDTH    (FRAME_WIDTH),
      .FRAME_HEIGHT   (FRAME_HEIGHT)
   ) u_xform (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_accept),
      .in_data   (req_data),
      .cfg       (cfg_ff),
      .out_stage (xf_stage)
   );

   // image store: loads and renders reach it in order at the same stage
   assign store_addr = xf_stage.store_addr[AW-1:0];

   always_ff @(posedge clock) begin
      if (xf_stage.valid && xf_stage.load_en) begin
         store_mem[store_addr] <= xf_stage.pixel;
      end
      if (xf_stage.valid && xf_stage.render) begin
         rd_data_ff <= store_mem[store_addr];
      end
   end

   assign s5_valid_in = xf_stage.valid && xf_stage.render;

   always_ff @(posedge clock) begin
      s5_rejected_ff <= xf_stage.rejected;
      s5_in_image_ff <= xf_stage.in_image;
      s5_frame_ff    <= xf_stage.frame_addr;
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff <= s5_valid_in;
      end
   end

   always_comb begin
      rsp_push_data.color         = (s5_rejected_ff || !s5_in_image_ff) ? irb_pkg::BLACK
                                                                        : rd_data_ff;
      rsp_push_data.outside       = !s5_rejected_ff && !s5_in_image_ff;
      rsp_push_data.rejected      = s5_rejected_ff;
      rsp_push_data.frame_address = s5_rejected_ff ? '0 : s5_frame_ff;
   end

   irb_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (s5_valid_ff),
      .push_data  (rsp_push_data),
      .pop_ready  (rsp_ready),
      .pop_valid  (rsp_valid),
      .pop_data   (rsp_data),
      .status     (fifo_status)
   );

   `IRB_ASSERT_RST(a_queue_within_credit, fifo_status.count <= pend_ff, "queue holds more results than pending renders")
   `IRB_ASSERT_RST(a_no_queue_overflow, s5_valid_ff |-> ((fifo_status.count < CNT_W'(irb_pkg::FIFO_DEPTH)) || rsp_pop), "result pushed into a full queue")
   `IRB_ASSERT_RST(a_render_counted, render_accept |=> (pend_ff != '0), "accepted render not counted as pending")
   `IRB_ASSERT_ALWAYS(a_ready_after_reset, reset |=> req_ready, "request channel not ready after reset")

endmodule
